// ----- rtl/core/image_convolution_3x3_core_defines.svh -----
// assertion macros shared by the convolution core files
`ifndef IMAGE_CONVOLUTION_3X3_CORE_DEFINES_SVH
`define IMAGE_CONVOLUTION_3X3_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// implication or plain property, checked on every rising edge out of reset
`define IMC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("imc assertion failed");
// condition that must never be true
`define IMC_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("imc forbidden condition seen");
`else
`define IMC_ASSERT(lbl, clk, rst_n, prop)
`define IMC_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- rtl/core/imc_pkg.sv -----
`default_nettype none

package imc_pkg;

	localparam int PIX_W      = 8;
	localparam int DIM_W      = 12;
	localparam int ROW_W      = 12;
	localparam int CMP_W      = 14;
	localparam int COEF_W     = 16;
	localparam int KERN       = 3;
	localparam int ROW_COEF_W = KERN * COEF_W;
	localparam int PROD_W     = PIX_W + COEF_W;
	localparam int COLSUM_W   = PROD_W + 2;
	localparam int SUM_W      = COLSUM_W + 2;
	localparam int MAX_HEIGHT = 2048;
	localparam int DIM_MIN    = 3;
	localparam int CFG_IDX_W  = 3;

	localparam logic [DIM_W-1:0]      WIDTH_RST    = 12'd640;
	localparam logic [DIM_W-1:0]      HEIGHT_RST   = 12'd480;
	localparam logic [ROW_COEF_W-1:0] COEF_TOP_RST = 48'd0;
	localparam logic [ROW_COEF_W-1:0] COEF_MID_RST = 48'd16384;
	localparam logic [ROW_COEF_W-1:0] COEF_BOT_RST = 48'd0;

	typedef logic [PIX_W-1:0] pix_t;
	// index 0 is the row above, 2 the row below
	typedef logic [KERN-1:0][PIX_W-1:0] pix_col_t;
	typedef logic [KERN-1:0][COEF_W-1:0] coef_col_t;
	typedef logic [COLSUM_W-1:0] colsum_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_COEF_TOP     = 3'd2,
		REG_COEF_MID     = 3'd3,
		REG_COEF_BOTTOM  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic vld;
		logic border;
		logic last;
	} ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/imc_in_if.sv -----
`default_nettype none

interface imc_in_if;
	import imc_pkg::*;

	logic valid;
	logic ready;
	logic op;
	pix_t pixel_in;

	modport source (output valid, output op, output pixel_in, input ready);
	modport sink (input valid, input op, input pixel_in, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/imc_out_if.sv -----
`default_nettype none

interface imc_out_if;
	import imc_pkg::*;

	logic valid;
	logic ready;
	pix_t pixel_out;
	logic frame_last;

	modport source (output valid, output pixel_out, output frame_last, input ready);
	modport sink (input valid, input pixel_out, input frame_last, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/imc_line_buf.sv -----
`default_nettype none

module imc_line_buf #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           adv,
	input  wire logic                           take,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]   rd_col,
	input  wire logic                           vld_s1,
	input  wire imc_pkg::pix_t                  pix_s1,
	output imc_pkg::pix_t                       top_o,
	output imc_pkg::pix_t                       mid_o
);
	import imc_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	pix_t upper_mem [MAX_WIDTH];
	pix_t lower_mem [MAX_WIDTH];

	pix_t             rd_upper_s1;
	pix_t             rd_lower_s1;
	pix_t             prev_mid_q;
	pix_t             prev_pix_q;
	logic             hit_s1;
	logic [COL_W-1:0] col_s1;
	pix_t             top_eff;
	pix_t             mid_eff;

	// back-to-back access of one column: take what the previous item wrote
	always_comb begin
		top_eff = hit_s1 ? prev_mid_q : rd_upper_s1;
		mid_eff = hit_s1 ? prev_pix_q : rd_lower_s1;
	end

	assign top_o = top_eff;
	assign mid_o = mid_eff;

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_upper_s1 <= upper_mem[rd_col];
			rd_lower_s1 <= lower_mem[rd_col];
		end
		if (adv && vld_s1) begin
			upper_mem[col_s1] <= mid_eff;
			lower_mem[col_s1] <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1 <= rd_col;
		end
		if (adv && vld_s1) begin
			prev_mid_q <= mid_eff;
			prev_pix_q <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else if (adv) begin
			hit_s1 <= take && vld_s1 && (col_s1 == rd_col);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/imc_cell.sv -----
`default_nettype none

module imc_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               load,
	input  wire imc_pkg::pix_col_t  pix_i,
	input  wire imc_pkg::coef_col_t coef_i,
	output imc_pkg::pix_col_t       pix_o,
	output imc_pkg::colsum_t        colsum_o
);
	import imc_pkg::*;

	pix_col_t          pix_q;
	logic [PROD_W-1:0] prod_s3 [KERN];
	colsum_t           colsum_s4;

	// one window column, handed to the left neighbor on every new pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (adv && load) begin
			pix_q <= pix_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < KERN; r++) begin
				prod_s3[r] <= PROD_W'(pix_q[r]) * PROD_W'(coef_i[r]);
			end
			colsum_s4 <= COLSUM_W'(prod_s3[0]) + COLSUM_W'(prod_s3[1])
				+ COLSUM_W'(prod_s3[2]);
		end
	end

	assign pix_o    = pix_q;
	assign colsum_o = colsum_s4;

endmodule

`default_nettype wire

// ----- rtl/core/imc_out_stage.sv -----
`default_nettype none

`include "image_convolution_3x3_core_defines.svh"

module imc_out_stage #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	input  wire logic                                               ready,
	input  wire imc_pkg::ctl_t                                      ctl_s4,
	input  wire imc_pkg::pix_t                                      center_s4,
	input  wire logic [imc_pkg::KERN-1:0][imc_pkg::COLSUM_W-1:0]   colsum_s4,
	output logic                                                    adv,
	output logic                                                    out_vld,
	output imc_pkg::pix_t                                           out_pix,
	output logic                                                    out_last
);
	import imc_pkg::*;

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] shifted;
	pix_t             filt;
	pix_t             res_pix;
	logic             res_vld;
	logic             take;

	logic out_vld_q;
	pix_t out_pix_q;
	logic out_last_q;
	logic skid_vld_q;
	pix_t skid_pix_q;
	logic skid_last_q;

	always_comb begin
		sum = SUM_W'(colsum_s4[0]) + SUM_W'(colsum_s4[1]) + SUM_W'(colsum_s4[2]);
		shifted = sum >> COEF_FRAC_BITS;
		filt = (shifted > SUM_W'(255)) ? 8'hFF : shifted[PIX_W-1:0];
		res_pix = ctl_s4.border ? center_s4 : filt;
	end

	assign adv     = !skid_vld_q;
	assign res_vld = adv && ctl_s4.vld;
	assign take    = out_vld_q && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (res_vld) begin
			if (out_vld_q && !take) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_pix_q  <= skid_pix_q;
				out_last_q <= skid_last_q;
			end
		end else if (res_vld) begin
			if (out_vld_q && !take) begin
				skid_pix_q  <= res_pix;
				skid_last_q <= ctl_s4.last;
			end else begin
				out_pix_q  <= res_pix;
				out_last_q <= ctl_s4.last;
			end
		end
	end

	assign out_vld  = out_vld_q;
	assign out_pix  = out_pix_q;
	assign out_last = out_last_q;

	`IMC_NEVER(a_skid_without_out, clk, arst_n, skid_vld_q && !out_vld_q)
	`IMC_ASSERT(a_skid_catches, clk, arst_n, (res_vld && out_vld_q && !ready) |=> skid_vld_q)

endmodule

`default_nettype wire

// ----- rtl/core/image_convolution_3x3_core.sv -----
// channel    | role   | payload                         | transaction when
// -----------+--------+---------------------------------+------------------------
// pixels     | sink   | op, pixel_in                    | valid && ready
// filtered   | source | pixel_out, frame_last           | valid && ready
// cfg        | write  | cfg_index, cfg_wdata            | cfg_we high
//
// one pixel per clock sustained; ready drops only while the skid entry holds a result
// a result goes from its transaction through s1, the window cells, products and column sums to the output register
// the row of three mac cells plus line store read and final sum form a fixed 5-deep pipe
// reset clears control, window and registers; line stores stay undefined, no clearing pass
// a stalled output keeps the whole pipe frozen, payloads held in place
`default_nettype none

`include "image_convolution_3x3_core_defines.svh"

module image_convolution_3x3_core #(
	parameter int MAX_WIDTH      = 2048,
	parameter int COEF_FRAC_BITS = 14
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [imc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [imc_pkg::ROW_COEF_W-1:0]    cfg_wdata,
	imc_in_if.sink                                 pixels,
	imc_out_if.source                              filtered
);
	import imc_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	// geometry and kernel registers
	logic [DIM_W-1:0]      width_q;
	logic [DIM_W-1:0]      height_q;
	logic [ROW_COEF_W-1:0] coef_q [KERN];

	// frame position of the next input pixel
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// accept-side decode
	logic             adv;
	logic             done;
	logic             take;
	pix_t             pix_new;
	logic             col_nz;
	logic             row_ge2;
	logic             emit;
	logic [ROW_W-1:0] orow;
	logic [CMP_W-1:0] ocol;
	logic [ROW_W-1:0] h_m1;
	logic [CMP_W-1:0] w_m1;
	logic [CMP_W-1:0] col_inc;
	logic             wrap;
	logic             border;
	logic             last;

	// pipeline
	logic     item_vld_s1;
	ctl_t     ctl_s1;
	ctl_t     ctl_s2;
	ctl_t     ctl_s3;
	ctl_t     ctl_s4;
	pix_t     pix_s1;
	pix_t     center_s3;
	pix_t     center_s4;
	pix_t     top_pix;
	pix_t     mid_pix;
	pix_col_t win [1:KERN];
	coef_col_t coef_col [KERN];
	logic [KERN-1:0][COLSUM_W-1:0] colsums;

	logic out_vld;
	pix_t out_pix;
	logic out_last;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [CMP_W-1:0] hi);
		logic [DIM_W-1:0] r;
		if (v < DIM_W'(DIM_MIN)) begin
			r = DIM_W'(DIM_MIN);
		end else if (CMP_W'(v) > hi) begin
			r = hi[DIM_W-1:0];
		end else begin
			r = v;
		end
		return r;
	endfunction

	// a flush is dropped until every pixel of the frame is in;
	// after that any item drains one pending output with a zero pixel
	always_comb begin
		done    = row_q >= ROW_W'(height_q);
		take    = pixels.valid && adv && !(pixels.op && !done);
		pix_new = done ? '0 : pixels.pixel_in;
		col_nz  = col_q != '0;
		row_ge2 = row_q >= ROW_W'(2);
		emit    = row_ge2 || ((row_q == ROW_W'(1)) && col_nz);
		h_m1    = ROW_W'(height_q) - ROW_W'(1);
		w_m1    = CMP_W'(width_q) - CMP_W'(1);
		// output position trails the input by one row and one pixel
		if (col_nz) begin
			orow = row_q - ROW_W'(1);
			ocol = CMP_W'(col_q) - CMP_W'(1);
		end else begin
			orow = row_ge2 ? (row_q - ROW_W'(2)) : '0;
			ocol = w_m1;
		end
		border  = (orow == '0) || (orow >= h_m1) || (ocol == '0) || (ocol >= w_m1);
		last    = (orow >= h_m1) && (ocol >= w_m1);
		col_inc = CMP_W'(col_q) + CMP_W'(1);
		wrap    = col_inc >= CMP_W'(width_q);
	end

	assign pixels.ready = adv;

	// configuration and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
			coef_q[0] <= COEF_TOP_RST;
			coef_q[1] <= COEF_MID_RST;
			coef_q[2] <= COEF_BOT_RST;
			col_q     <= '0;
			row_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH: begin
					width_q <= clamp_dim(cfg_wdata[DIM_W-1:0], CMP_W'(MAX_WIDTH));
					col_q   <= '0;
					row_q   <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= clamp_dim(cfg_wdata[DIM_W-1:0], CMP_W'(MAX_HEIGHT));
					col_q    <= '0;
					row_q    <= '0;
				end
				REG_COEF_TOP:    coef_q[0] <= cfg_wdata;
				REG_COEF_MID:    coef_q[1] <= cfg_wdata;
				REG_COEF_BOTTOM: coef_q[2] <= cfg_wdata;
				default: ;
			endcase
		end else if (take) begin
			if (emit && last) begin
				// end of frame: next pixel starts a new one
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	// control pipe, frozen together with the payload while the output stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			ctl_s4      <= '0;
		end else if (adv) begin
			item_vld_s1 <= take;
			ctl_s1      <= '{vld: take && emit, border: border, last: last};
			ctl_s2      <= ctl_s1;
			ctl_s3      <= ctl_s2;
			ctl_s4      <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1    <= pix_new;
			center_s3 <= win[1][1];
			center_s4 <= center_s3;
		end
	end

	// two line stores: read at the accept edge, rotated as the item leaves s1
	imc_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.take   (take),
		.rd_col (col_q),
		.vld_s1 (item_vld_s1),
		.pix_s1 (pix_s1),
		.top_o  (top_pix),
		.mid_o  (mid_pix)
	);

	// newest column enters the right cell
	assign win[KERN][0] = top_pix;
	assign win[KERN][1] = mid_pix;
	assign win[KERN][2] = pix_s1;

	// kernel column c gathers coefficient c of every kernel row
	always_comb begin
		for (int c = 0; c < KERN; c++) begin
			for (int r = 0; r < KERN; r++) begin
				coef_col[c][r] = coef_q[r][COEF_W*c +: COEF_W];
			end
		end
	end

	// chain of three mac cells, right to left
	for (genvar c = 0; c < KERN; c++) begin : g_cell
		if (c == 0) begin : g_left
			imc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.load     (item_vld_s1),
				.pix_i    (win[c+1]),
				.coef_i   (coef_col[c]),
				.pix_o    (),
				.colsum_o (colsums[c])
			);
		end else begin : g_inner
			imc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.load     (item_vld_s1),
				.pix_i    (win[c+1]),
				.coef_i   (coef_col[c]),
				.pix_o    (win[c]),
				.colsum_o (colsums[c])
			);
		end
	end

	// final sum, scale, saturate, border select, output register and skid
	imc_out_stage #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.ready     (filtered.ready),
		.ctl_s4    (ctl_s4),
		.center_s4 (center_s4),
		.colsum_s4 (colsums),
		.adv       (adv),
		.out_vld   (out_vld),
		.out_pix   (out_pix),
		.out_last  (out_last)
	);

	assign filtered.valid      = out_vld;
	assign filtered.pixel_out  = out_pix;
	assign filtered.frame_last = out_last;

	`IMC_ASSERT(a_col_in_row, clk, arst_n, CMP_W'(col_q) < CMP_W'(width_q))
	`IMC_ASSERT(a_row_bounded, clk, arst_n, CMP_W'(row_q) <= (CMP_W'(height_q) + CMP_W'(1)))

endmodule

`default_nettype wire

// ----- dv/imc_filter_check.sv -----
// watches the pixel, filtered and register channels, predicts every filtered pixel
// and compares it field by field with what the core hands out
module imc_filter_check
	import imc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ROW_COEF_W-1:0] cfg_wdata,
	imc_in_if                          pixels,
	imc_out_if                         filtered,
	output int                         mismatches,
	output int                         awaiting,
	output int                         results_seen,
	output int                         frames_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH = 2048;
	localparam int FRAC_BITS  = 14;

	typedef struct packed {
		pix_t value;
		logic last;
	} out_pix_t;

	int unsigned           img_w;
	int unsigned           img_h;
	logic [ROW_COEF_W-1:0] kern_rows [KERN];
	pix_t                  upper_line [LINE_DEPTH];
	pix_t                  lower_line [LINE_DEPTH];
	pix_t                  win [KERN][KERN];
	int unsigned           col_pos;
	int unsigned           row_pos;
	out_pix_t              expected_px [$];
	int                    err_count;
	int                    result_count;
	int                    frame_count;

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw, input int unsigned hi);
		if (raw < DIM_MIN)
			return DIM_MIN;
		if (raw > hi)
			return hi;
		return raw;
	endfunction

	// weighted sum of the window, truncated to integer and saturated
	function automatic pix_t window_sum();
		logic [31:0] acc;
		acc = '0;
		for (int r = 0; r < KERN; r++)
			for (int c = 0; c < KERN; c++)
				acc += 32'(kern_rows[r][c*COEF_W +: COEF_W]) * 32'(win[r][c]);
		acc = acc >> FRAC_BITS;
		return (acc > 32'd255) ? 8'hFF : acc[7:0];
	endfunction

	// advances the frame by one item, queues the filtered pixel it releases
	function automatic void convolve_pixel(input logic flush_item, input pix_t pin);
		int unsigned c;
		int unsigned r;
		int unsigned o_row;
		int unsigned o_col;
		logic        emit;
		logic        border;
		pix_t        p;
		pix_t        above;
		pix_t        centre;
		out_pix_t    res;
		c = col_pos;
		r = row_pos;
		// flush while the frame is still open: dropped
		if (flush_item && r < img_h)
			return;
		p = (r >= img_h) ? '0 : pin;
		above = upper_line[c];
		centre = lower_line[c];
		upper_line[c] = centre;
		lower_line[c] = p;
		for (int k = 0; k < KERN; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = above;
		win[1][2] = centre;
		win[2][2] = p;
		emit = (r >= 2) || (r == 1 && c >= 1);
		if (c >= 1) begin
			o_row = r - 1;
			o_col = c - 1;
		end else begin
			o_row = (r >= 2) ? r - 2 : 0;
			o_col = img_w - 1;
		end
		c++;
		if (c >= img_w) begin
			c = 0;
			r++;
		end
		col_pos = c;
		row_pos = r;
		if (!emit)
			return;
		border = o_row == 0 || o_row >= img_h - 1 || o_col == 0 || o_col >= img_w - 1;
		res.value = border ? win[1][1] : window_sum();
		res.last = (o_row >= img_h - 1) && (o_col >= img_w - 1);
		if (res.last) begin
			col_pos = 0;
			row_pos = 0;
		end
		expected_px.push_back(res);
	endfunction

	function automatic void report(input string msg);
		err_count++;
		$display("%0t ns: %s", $time, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_pix_t want;
		if (!arst_n) begin
			img_w = WIDTH_RST;
			img_h = HEIGHT_RST;
			kern_rows[0] = COEF_TOP_RST;
			kern_rows[1] = COEF_MID_RST;
			kern_rows[2] = COEF_BOT_RST;
			for (int i = 0; i < LINE_DEPTH; i++) begin
				upper_line[i] = '0;
				lower_line[i] = '0;
			end
			for (int r = 0; r < KERN; r++)
				for (int c = 0; c < KERN; c++)
					win[r][c] = '0;
			col_pos = 0;
			row_pos = 0;
			expected_px.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: begin
						img_w = clamp_dim(cfg_wdata[DIM_W-1:0], LINE_DEPTH);
						col_pos = 0;
						row_pos = 0;
					end
					REG_IMAGE_HEIGHT: begin
						img_h = clamp_dim(cfg_wdata[DIM_W-1:0], MAX_HEIGHT);
						col_pos = 0;
						row_pos = 0;
					end
					REG_COEF_TOP:    kern_rows[0] = cfg_wdata;
					REG_COEF_MID:    kern_rows[1] = cfg_wdata;
					REG_COEF_BOTTOM: kern_rows[2] = cfg_wdata;
					default: ;
				endcase
			end
			if (filtered.valid && filtered.ready) begin
				result_count++;
				if (expected_px.size() == 0) begin
					report($sformatf("result with nothing expected: pixel_out %0d frame_last %0b",
						filtered.pixel_out, filtered.frame_last));
				end else begin
					want = expected_px.pop_front();
					if (filtered.pixel_out !== want.value)
						report($sformatf("pixel_out expected %0d, actual %0d",
							want.value, filtered.pixel_out));
					if (filtered.frame_last !== want.last)
						report($sformatf("frame_last expected %0b, actual %0b",
							want.last, filtered.frame_last));
					if (want.last)
						frame_count++;
				end
			end
			if (pixels.valid && pixels.ready)
				convolve_pixel(pixels.op, pixels.pixel_in);
		end
		awaiting     <= expected_px.size();
		mismatches   <= err_count;
		results_seen <= result_count;
		frames_seen  <= frame_count;
	end

endmodule

// ----- dv/tb.sv -----
// stimulus and verdict for the 3x3 convolution core; all checking lives in imc_filter_check
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import imc_pkg::*;

	// item codes on the pixel channel
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// an index past the register list, must be ignored by the core
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam int          FRAC_BITS    = 14;
	localparam int          RANDOM_ITEMS = 260;
	localparam int          HOLD_CYCLES  = 300;
	// result passes a 5-deep pipe after its transaction: keep some slack
	localparam int          PIPE_SLACK   = 12;
	localparam int          DRAIN_LIMIT  = 5000;
	localparam int unsigned NO_HOLD      = 32'hFFFF_FFFF;

	typedef enum int {
		KERN_WILD,
		KERN_BLUR,
		KERN_EXTREME,
		KERN_PASS
	} kern_style_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [ROW_COEF_W-1:0] cfg_wdata;

	// hold_request asks the result sink for one long stall, calm switches idling off
	logic hold_request;
	logic calm;

	int mismatches;
	int awaiting;
	int results_seen;
	int frames_seen;

	int unsigned sent_items;
	int unsigned noise_items;
	int unsigned settings_used;

	imc_in_if  pix_if ();
	imc_out_if flt_if ();

	image_convolution_3x3_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pixels    (pix_if.sink),
		.filtered  (flt_if.source)
	);

	imc_filter_check i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.pixels       (pix_if),
		.filtered     (flt_if),
		.mismatches   (mismatches),
		.awaiting     (awaiting),
		.results_seen (results_seen),
		.frames_seen  (frames_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// one item on the pixel channel, with random idle cycles ahead of it unless calm
	task automatic put_item(input logic op, input pix_t pix);
		while (!calm && $urandom_range(99) < 25) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid    <= 1'b1;
		pix_if.op       <= op;
		pix_if.pixel_in <= pix;
		do @(posedge clk); while (!pix_if.ready);
		sent_items++;
	endtask

	// leaves cfg_we high; the caller lowers it after the last write of a burst
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_COEF_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// full register set; geometry carries junk above bit 11, which the core must drop
	task automatic load_settings(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw,
			input logic [ROW_COEF_W-1:0] k_top, input logic [ROW_COEF_W-1:0] k_mid,
			input logic [ROW_COEF_W-1:0] k_bot, input logic stray);
		put_reg(REG_IMAGE_WIDTH, {36'($urandom), w_raw});
		put_reg(REG_IMAGE_HEIGHT, {36'($urandom), h_raw});
		if (stray)
			put_reg(REG_UNUSED, {36'($urandom), 12'd5});
		put_reg(REG_COEF_TOP, k_top);
		put_reg(REG_COEF_MID, k_mid);
		put_reg(REG_COEF_BOTTOM, k_bot);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// wait until every predicted pixel came out, then let the pipe run empty
	task automatic settle();
		pix_if.valid <= 1'b0;
		@(posedge clk);
		for (int k = 0; k < DRAIN_LIMIT && awaiting != 0; k++)
			@(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	// one frame of random pixels with stray early flushes, then the drain items;
	// a cut below w*h stops the frame early and skips the drain
	task automatic run_frame(input int unsigned w, input int unsigned h,
			input int unsigned cut, input int unsigned hold_at);
		for (int unsigned n = 0; n < w * h && n < cut; n++) begin
			if ($urandom_range(99) < 5) begin
				// frame still open: the core drops it
				put_item(OP_FLUSH, pix_t'($urandom));
				noise_items++;
			end
			if (n == hold_at)
				hold_request <= 1'b1;
			put_item(OP_PIXEL, pix_t'($urandom));
		end
		if (cut < w * h)
			return;
		// once all pixels are in, a pixel item drains just like a flush
		for (int unsigned n = 0; n <= w; n++)
			put_item($urandom_range(1) ? OP_FLUSH : OP_PIXEL, pix_t'($urandom));
	endtask

	function automatic logic [ROW_COEF_W-1:0] kernel_row(input kern_style_t style, input int row);
		logic [ROW_COEF_W-1:0] k;
		k = '0;
		for (int c = 0; c < KERN; c++)
			case (style)
				KERN_WILD:    k[c*COEF_W +: COEF_W] = COEF_W'($urandom);
				KERN_BLUR:    k[c*COEF_W +: COEF_W] = COEF_W'($urandom_range(2048));
				KERN_EXTREME: k[c*COEF_W +: COEF_W] = $urandom_range(1) ? '1 : '0;
				default:      k[c*COEF_W +: COEF_W] = (row == 1 && c == 1) ? COEF_W'(1 << FRAC_BITS) : '0;
			endcase
		return k;
	endfunction

	// minimum size is sometimes written as 0..2, which the core clamps up
	function automatic logic [DIM_W-1:0] dim_code(input int unsigned d);
		if (d == DIM_MIN && $urandom_range(1))
			return DIM_W'($urandom_range(DIM_MIN - 1));
		return DIM_W'(d);
	endfunction

	initial begin : stimulus
		int unsigned w;
		int unsigned h;
		int unsigned frames;
		int unsigned cut;
		int unsigned goal;
		kern_style_t style;

		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_IMAGE_WIDTH;
		cfg_wdata       <= '0;
		pix_if.valid    <= 1'b0;
		pix_if.op       <= OP_PIXEL;
		pix_if.pixel_in <= '0;
		hold_request    <= 1'b0;
		calm            <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// all-ones kernel on the smallest frame, sizes written below the minimum,
		// plus a write to an index past the register list
		load_settings(12'd0, 12'd1, '1, '1, '1, 1'b1);
		put_item(OP_FLUSH, 8'hFF);
		for (int i = 0; i < 9; i++)
			put_item(OP_PIXEL, (i % 2) ? 8'h00 : 8'hFF);
		put_item(OP_FLUSH, 8'h00);
		put_item(OP_PIXEL, 8'h5A);
		put_item(OP_FLUSH, 8'hA5);
		put_item(OP_FLUSH, 8'h00);
		settle();

		// zero kernel: interior goes to 0, pixels carry a walking one bit, the ninth wraps to zero
		load_settings(12'd3, 12'd3, '0, '0, '0, 1'b0);
		for (int i = 0; i < 9; i++)
			put_item(OP_PIXEL, pix_t'(9'd1 << i));
		for (int i = 0; i < 4; i++)
			put_item(OP_PIXEL, pix_t'($urandom));
		settle();

		// the result sink holds off early in the frame while pixels keep coming
		load_settings(12'd8, 12'd4, kernel_row(KERN_BLUR, 0), kernel_row(KERN_BLUR, 1),
			kernel_row(KERN_BLUR, 2), 1'b0);
		run_frame(8, 4, 8 * 4, 8);
		settle();

		// random settings, mostly small frames, now and then a frame cut short
		goal = sent_items - noise_items + RANDOM_ITEMS;
		while (sent_items - noise_items < goal) begin
			w = ($urandom_range(5) == 0) ? $urandom_range(24, 13) : $urandom_range(12, DIM_MIN);
			h = $urandom_range(6, DIM_MIN);
			style = kern_style_t'($urandom_range(3));
			load_settings(dim_code(w), dim_code(h), kernel_row(style, 0), kernel_row(style, 1),
				kernel_row(style, 2), $urandom_range(4) == 0);
			frames = $urandom_range(2, 1);
			for (int unsigned f = 0; f < frames; f++) begin
				cut = (f == frames - 1 && $urandom_range(99) < 15) ?
					$urandom_range(w * h - 1, 1) : w * h;
				run_frame(w, h, cut, NO_HOLD);
			end
			settle();
		end

		// a whole frame with no idling on either side
		calm <= 1'b1;
		load_settings(12'd12, 12'd6, kernel_row(KERN_WILD, 0), kernel_row(KERN_WILD, 1),
			kernel_row(KERN_WILD, 2), 1'b0);
		run_frame(12, 6, 12 * 6, NO_HOLD);
		settle();
		calm <= 1'b0;
		@(posedge clk);

		if (awaiting != 0)
			$display("%0t ns: %0d filtered pixels still expected at end of run", $time, awaiting);
		$display("run covered %0d pixel channel transactions (%0d dropped early flushes), %0d results, %0d frames",
			sent_items, noise_items, results_seen, frames_seen);
		$display("over %0d register settings, 3x3 up to 24-pixel frames, one long result stall",
			settings_used);
		if (mismatches == 0 && awaiting == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// result sink: random stalls, none while calm, one long hold on request
	initial begin : result_sink
		logic hold_done;
		hold_done = 1'b0;
		flt_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				flt_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				flt_if.ready <= calm || ($urandom_range(99) >= 25);
			end
		end
	end

	initial begin : watchdog
		#10ms;
		$display("%0t ns: run timed out", $time);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
